// ----- rtl/tgs_pkg.sv -----
// ----------------------------------------------------------------------------
// tgs_pkg
// shared types, constants and blend arithmetic for the trilinear grid sampler
// ----------------------------------------------------------------------------
package tgs_pkg;

  localparam int GRID_CELLS = 32768;
  localparam int ADDR_W     = $clog2(GRID_CELLS);
  localparam int FRAC_BITS  = 8;
  localparam int VALUE_BITS = 16;
  localparam int DIM_W      = 6;
  localparam int COORD_W    = 16;
  localparam int CELL_W     = COORD_W - FRAC_BITS;
  localparam int ZY_W       = 2 * DIM_W;
  localparam int IDX_W      = 3 * DIM_W;
  localparam int NCORNER    = 8;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CELLS_X = 2'd0,
    CFG_CELLS_Y = 2'd1,
    CFG_CELLS_Z = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    ACT_WRITE  = 1'b0,
    ACT_SAMPLE = 1'b1
  } action_t;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [FRAC_BITS-1:0]  frac_t;

  // (a*(one-f))>>frac + (b*f)>>frac, each product truncated on its own
  function automatic value_t blend(input value_t a, input value_t b, input frac_t f);
    logic [FRAC_BITS:0]              wa;
    logic [VALUE_BITS+FRAC_BITS:0]   pa;
    logic [VALUE_BITS+FRAC_BITS:0]   pb;
    logic [VALUE_BITS:0]             s;
    wa = (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, f};
    pa = (VALUE_BITS+FRAC_BITS+1)'(a) * (VALUE_BITS+FRAC_BITS+1)'(wa);
    pb = (VALUE_BITS+FRAC_BITS+1)'(b) * (VALUE_BITS+FRAC_BITS+1)'(f);
    s  = pa[VALUE_BITS+FRAC_BITS:FRAC_BITS] + pb[VALUE_BITS+FRAC_BITS:FRAC_BITS];
    return s[VALUE_BITS-1:0];
  endfunction

endpackage

// ----- rtl/trilinear_grid_sampler.sv -----
// ----------------------------------------------------------------------------
// trilinear_grid_sampler
// a sample transfer passes stages 1 to 5, then the output register gives its density
// throughput: one item (write or sample) per cycle while in_stall is low, set by the
// 8 corner banks each serving one read per cycle
// reset: synchronous active-low rst_n clears the pipeline and sets all three
// dimensions to 32; grid memory is not cleared and holds garbage until written
// ----------------------------------------------------------------------------
module trilinear_grid_sampler (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_action,
  input  logic [14:0]                       in_cell_index,
  input  logic [15:0]                       in_cell_value,
  input  logic signed [15:0]                in_point_x,
  input  logic signed [15:0]                in_point_y,
  input  logic signed [15:0]                in_point_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [15:0]                       out_density,
  input  logic                              cfg_we,
  input  logic [tgs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tgs_pkg::DIM_W-1:0]         cfg_data
);

  localparam int AW = tgs_pkg::ADDR_W;
  localparam int VW = tgs_pkg::VALUE_BITS;
  localparam int FW = tgs_pkg::FRAC_BITS;
  localparam int DW = tgs_pkg::DIM_W;
  localparam int CW = tgs_pkg::CELL_W;
  localparam int NC = tgs_pkg::NCORNER;

  // configuration registers
  logic [DW-1:0] cx_r, cy_r, cz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= DW'(32);
      cy_r <= DW'(32);
      cz_r <= DW'(32);
    end else if (cfg_we) begin
      unique case (cfg_index)
        tgs_pkg::CFG_CELLS_X: cx_r <= cfg_data;
        tgs_pkg::CFG_CELLS_Y: cy_r <= cfg_data;
        tgs_pkg::CFG_CELLS_Z: cz_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // whole pipeline moves together; the output register parts the two sides
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  logic acc;
  assign acc = in_valid && adv;

  // ---------------- stage 1: floor, bounds and z*cy+y ----------------
  logic [CW-1:0]  x0, y0, z0;
  logic [CW:0]    x1, y1, z1;
  logic [1:0]     inx, iny, inz;
  logic [DW-1:0]  xs [2];
  logic [DW-1:0]  ys [2];
  logic [DW-1:0]  zs [2];

  assign x0 = in_point_x[15:FW];
  assign y0 = in_point_y[15:FW];
  assign z0 = in_point_z[15:FW];
  assign x1 = {x0[CW-1], x0} + (CW+1)'(1);
  assign y1 = {y0[CW-1], y0} + (CW+1)'(1);
  assign z1 = {z0[CW-1], z0} + (CW+1)'(1);

  // a coordinate is inside when non-negative and below the dimension
  assign inx[0] = !x0[CW-1] && ({1'b0, x0[CW-2:0]} < CW'(cx_r));
  assign inx[1] = !x1[CW]   && (x1[CW-1:0] < CW'(cx_r));
  assign iny[0] = !y0[CW-1] && ({1'b0, y0[CW-2:0]} < CW'(cy_r));
  assign iny[1] = !y1[CW]   && (y1[CW-1:0] < CW'(cy_r));
  assign inz[0] = !z0[CW-1] && ({1'b0, z0[CW-2:0]} < CW'(cz_r));
  assign inz[1] = !z1[CW]   && (z1[CW-1:0] < CW'(cz_r));
  assign xs[0] = x0[DW-1:0];
  assign xs[1] = x1[DW-1:0];
  assign ys[0] = y0[DW-1:0];
  assign ys[1] = y1[DW-1:0];
  assign zs[0] = z0[DW-1:0];
  assign zs[1] = z1[DW-1:0];

  logic                     v1_r, smp1_r;
  logic [tgs_pkg::ZY_W-1:0] zy1_r [4];
  logic [3:0]               inzy1_r;
  logic [DW-1:0]            xs1_r [2];
  logic [1:0]               inx1_r;
  logic [FW-1:0]            fx1_r, fy1_r, fz1_r;
  logic [AW-1:0]            widx1_r;
  logic [VW-1:0]            wval1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= acc;
    end
  end

  // index of the row list: bit0 y offset, bit1 z offset
  always_ff @(posedge clk) begin
    if (adv) begin
      smp1_r  <= (in_action == tgs_pkg::ACT_SAMPLE);
      for (int r = 0; r < 4; r++) begin
        zy1_r[r]   <= tgs_pkg::ZY_W'(zs[r/2] * cy_r) + tgs_pkg::ZY_W'(ys[r%2]);
        inzy1_r[r] <= inz[r/2] && iny[r%2];
      end
      xs1_r[0] <= xs[0];
      xs1_r[1] <= xs[1];
      inx1_r   <= inx;
      fx1_r    <= in_point_x[FW-1:0];
      fy1_r    <= in_point_y[FW-1:0];
      fz1_r    <= in_point_z[FW-1:0];
      widx1_r  <= in_cell_index;
      wval1_r  <= in_cell_value;
    end
  end

  // ---------------- stage 2: corner addresses ----------------
  // corner k: bit0 x offset, bit1 y offset, bit2 z offset
  logic                      v2_r, smp2_r;
  logic [AW-1:0]             addr2_r [NC];
  logic [NC-1:0]             ok2_r;
  logic [FW-1:0]             fx2_r, fy2_r, fz2_r;
  logic [AW-1:0]             widx2_r;
  logic [VW-1:0]             wval2_r;
  logic [tgs_pkg::IDX_W-1:0] lin [NC];

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      lin[k] = tgs_pkg::IDX_W'(zy1_r[k/2] * cx_r) + tgs_pkg::IDX_W'(xs1_r[k%2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      smp2_r <= smp1_r;
      for (int k = 0; k < NC; k++) begin
        addr2_r[k] <= lin[k][AW-1:0];
        ok2_r[k]   <= inx1_r[k%2] && inzy1_r[k/2] &&
                      (lin[k] < tgs_pkg::IDX_W'(tgs_pkg::GRID_CELLS));
      end
      fx2_r   <= fx1_r;
      fy2_r   <= fy1_r;
      fz2_r   <= fz1_r;
      widx2_r <= widx1_r;
      wval2_r <= wval1_r;
    end
  end

  // ---------------- stage 3: eight corner banks ----------------
  // every bank holds a full copy; writes go to all, each bank serves one corner
  logic [VW-1:0] grid_mem [NC][tgs_pkg::GRID_CELLS];
  logic [VW-1:0] rd3_r [NC];
  logic          mem_we;
  logic          v3_r, smp3_r;
  logic [NC-1:0] ok3_r;
  logic [FW-1:0] fx3_r, fy3_r, fz3_r;

  assign mem_we = adv && v2_r && !smp2_r;

  for (genvar b = 0; b < NC; b++) begin : g_bank
    always_ff @(posedge clk) begin
      if (mem_we) begin
        grid_mem[b][widx2_r] <= wval2_r;
      end
      if (adv) begin
        rd3_r[b] <= grid_mem[b][addr2_r[b]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r && smp2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      smp3_r <= smp2_r;
      ok3_r  <= ok2_r;
      fx3_r  <= fx2_r;
      fy3_r  <= fy2_r;
      fz3_r  <= fz2_r;
    end
  end

  // ---------------- stage 4: blend along x ----------------
  logic [VW-1:0] cor [NC];
  logic          v4_r;
  logic [VW-1:0] cx4_r [4];
  logic [FW-1:0] fy4_r, fz4_r;

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      cor[k] = ok3_r[k] ? rd3_r[k] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r && smp3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 4; r++) begin
        cx4_r[r] <= tgs_pkg::blend(cor[2*r], cor[2*r+1], fx3_r);
      end
      fy4_r <= fy3_r;
      fz4_r <= fz3_r;
    end
  end

  // ---------------- stage 5: blend along y ----------------
  logic          v5_r;
  logic [VW-1:0] cy5_r [2];
  logic [FW-1:0] fz5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (adv) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cy5_r[0] <= tgs_pkg::blend(cx4_r[0], cx4_r[1], fy4_r);
      cy5_r[1] <= tgs_pkg::blend(cx4_r[2], cx4_r[3], fy4_r);
      fz5_r    <= fz4_r;
    end
  end

  // ---------------- output register: blend along z ----------------
  logic          ov_r;
  logic [VW-1:0] dens_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dens_r <= tgs_pkg::blend(cy5_r[0], cy5_r[1], fz5_r);
    end
  end

  assign out_valid   = ov_r;
  assign out_density = dens_r;

endmodule

// ----- rtl/tgs_checker.sv -----
// ----------------------------------------------------------------------------
// tgs_checker
// port-level checks for the trilinear grid sampler
// ----------------------------------------------------------------------------
module tgs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_density
);

  // input side stalls exactly when a finished result is held back
  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("in_stall not tied to output backpressure");

  // nothing is shown right after reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid after reset");

  // a held result keeps its density
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_density))
    else $error("stalled result changed");

  // a result can only rise when the input side was not stalled just before
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_stall))
    else $error("result appeared during stall");

endmodule

bind trilinear_grid_sampler tgs_checker u_tgs_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_density (out_density)
);

// ----- dv/trilinear_grid_sampler_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trilinear_grid_sampler_tb
// self-checking bench: loads grid cells, samples points and checks each
// density against an in-bench trilinear predictor or a fixed expected value under several grid shapes
// ----------------------------------------------------------------------------
module trilinear_grid_sampler_tb;

  localparam logic [tgs_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 300;
  localparam int RAND_PER_PHASE = 75;
  localparam int NUM_PHASES     = 9;

  typedef struct {
    tgs_pkg::action_t   act;
    logic [14:0]        idx;
    logic [15:0]        val;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] pz;
    bit                 has_exp;
    logic [15:0]        exp_density;
  } grid_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_action = 1'b0;
  logic [14:0] in_cell_index = '0;
  logic [15:0] in_cell_value = '0;
  logic signed [15:0] in_point_x = '0;
  logic signed [15:0] in_point_y = '0;
  logic signed [15:0] in_point_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] out_density;
  logic cfg_we = 1'b0;
  logic [tgs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tgs_pkg::DIM_W-1:0] cfg_data = '0;

  trilinear_grid_sampler dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_cell_index(in_cell_index), .in_cell_value(in_cell_value),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_point_z(in_point_z),
    .out_valid(out_valid), .out_stall(out_stall), .out_density(out_density),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bench copy of the grid and the dimension registers
  logic [15:0] grid_mem [tgs_pkg::GRID_CELLS];
  bit          cell_written [tgs_pkg::GRID_CELLS];
  int          dim_x = 32;
  int          dim_y = 32;
  int          dim_z = 32;

  logic [15:0] density_q [$];
  int          errors = 0;
  int          burst_left = 0;
  int          hold_reqs = 0;

  // sample box for the current phase
  int box_x0, box_y0, box_z0, box_w, box_h, box_d;

  // corner fetch: outside the dims or past the store counts as zero
  function automatic longint corner_index(int x, int y, int z);
    if (x < 0 || x >= dim_x || y < 0 || y >= dim_y || z < 0 || z >= dim_z) begin
      return -1;
    end
    return (longint'(z) * dim_y + y) * dim_x + x;
  endfunction

  function automatic longint corner_value(int x, int y, int z);
    longint ci;
    ci = corner_index(x, y, z);
    if (ci < 0 || ci >= tgs_pkg::GRID_CELLS) return 0;
    return grid_mem[ci];
  endfunction

  function automatic longint lerp_trunc(longint a, longint b, longint f);
    return ((a * (256 - f)) >>> tgs_pkg::FRAC_BITS) + ((b * f) >>> tgs_pkg::FRAC_BITS);
  endfunction

  function automatic logic [15:0] predict_density(logic signed [15:0] px,
                                                  logic signed [15:0] py,
                                                  logic signed [15:0] pz);
    int x0, y0, z0;
    longint fx, fy, fz, c00, c01, c10, c11, c0, c1;
    // floor and fraction of each axis
    x0 = int'(px >>> tgs_pkg::FRAC_BITS);
    y0 = int'(py >>> tgs_pkg::FRAC_BITS);
    z0 = int'(pz >>> tgs_pkg::FRAC_BITS);
    fx = px[tgs_pkg::FRAC_BITS-1:0];
    fy = py[tgs_pkg::FRAC_BITS-1:0];
    fz = pz[tgs_pkg::FRAC_BITS-1:0];
    c00 = lerp_trunc(corner_value(x0, y0, z0), corner_value(x0+1, y0, z0), fx);
    c01 = lerp_trunc(corner_value(x0, y0, z0+1), corner_value(x0+1, y0, z0+1), fx);
    c10 = lerp_trunc(corner_value(x0, y0+1, z0), corner_value(x0+1, y0+1, z0), fx);
    c11 = lerp_trunc(corner_value(x0, y0+1, z0+1), corner_value(x0+1, y0+1, z0+1), fx);
    c0 = lerp_trunc(c00, c10, fy);
    c1 = lerp_trunc(c01, c11, fy);
    return 16'(lerp_trunc(c0, c1, fz));
  endfunction

  // a point is usable only if every in-store corner was loaded
  function automatic bit corners_loaded(logic signed [15:0] px,
                                        logic signed [15:0] py,
                                        logic signed [15:0] pz);
    int x0, y0, z0;
    longint ci;
    x0 = int'(px >>> tgs_pkg::FRAC_BITS);
    y0 = int'(py >>> tgs_pkg::FRAC_BITS);
    z0 = int'(pz >>> tgs_pkg::FRAC_BITS);
    for (int c = 0; c < tgs_pkg::NCORNER; c++) begin
      ci = corner_index(x0 + c[0], y0 + c[1], z0 + c[2]);
      if (ci >= 0 && ci < tgs_pkg::GRID_CELLS && !cell_written[ci]) return 0;
    end
    return 1;
  endfunction

  // one transfer on the input channel, then update the bench state
  task automatic send_item(grid_req_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_action     <= r.act;
    in_cell_index <= r.idx;
    in_cell_value <= r.val;
    in_point_x    <= r.px;
    in_point_y    <= r.py;
    in_point_z    <= r.pz;
    do @(posedge clk); while (in_stall);
    if (r.act == tgs_pkg::ACT_WRITE) begin
      grid_mem[r.idx]     = r.val;
      cell_written[r.idx] = 1'b1;
    end else if (r.has_exp) begin
      density_q.push_back(r.exp_density);
    end else begin
      density_q.push_back(predict_density(r.px, r.py, r.pz));
    end
  endtask

  // stop sending and wait until every density has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (density_q.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_dims(int nx, int ny, int nz);
    cfg_we <= 1'b1; cfg_index <= tgs_pkg::CFG_CELLS_X; cfg_data <= tgs_pkg::DIM_W'(nx);
    @(posedge clk);
    cfg_index <= tgs_pkg::CFG_CELLS_Y; cfg_data <= tgs_pkg::DIM_W'(ny);
    @(posedge clk);
    cfg_index <= tgs_pkg::CFG_CELLS_Z; cfg_data <= tgs_pkg::DIM_W'(nz);
    @(posedge clk);
    // index past the three registers is ignored
    cfg_index <= CFG_UNUSED; cfg_data <= tgs_pkg::DIM_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    dim_x = nx; dim_y = ny; dim_z = nz;
  endtask

  function automatic grid_req_t write_req(int index, logic [15:0] value);
    grid_req_t r;
    r = '{tgs_pkg::ACT_WRITE, 15'(index), value, '0, '0, '0, 1'b0, '0};
    return r;
  endfunction

  function automatic grid_req_t sample_req(logic [15:0] x, logic [15:0] y,
                                           logic [15:0] z, bit known,
                                           logic [15:0] d);
    grid_req_t r;
    r = '{tgs_pkg::ACT_SAMPLE, 15'($urandom), 16'($urandom), x, y, z, known, d};
    return r;
  endfunction

  function automatic logic [15:0] axis_coord(int base, int span);
    int cell_n;
    logic [7:0] frac;
    cell_n = base - 1 + $urandom_range(0, span);
    frac = ($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom);
    return 16'(cell_n * 256 + frac);
  endfunction

  function automatic grid_req_t random_sample();
    logic [15:0] x, y, z;
    for (int t = 0; t < 16; t++) begin
      if ($urandom_range(0, 6) == 0) begin
        x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
      end else begin
        x = axis_coord(box_x0, box_w);
        y = axis_coord(box_y0, box_h);
        z = axis_coord(box_z0, box_d);
      end
      if (corners_loaded(x, y, z)) return sample_req(x, y, z, 1'b0, '0);
    end
    // every corner far outside the grid
    return sample_req(16'h8000, 16'h8000, 16'h8000, 1'b0, '0);
  endfunction

  // directed rows, run with the reset dimensions of 32 per axis
  grid_req_t directed_rows [$];

  initial begin
    directed_rows = '{
      write_req(0,     16'hFFFF), write_req(1,    16'h0000),
      write_req(32,    16'h1234), write_req(33,   16'h8000),
      write_req(1024,  16'h00FF), write_req(1025, 16'hFF00),
      write_req(1056,  16'h7FFF), write_req(1057, 16'h0001),
      write_req(32767, 16'hABCD),
      // on a grid point the weight is all on the low corner
      sample_req(16'h0000, 16'h0000, 16'h0000, 1'b1, 16'hFFFF),
      // far negative and far positive: every corner outside
      sample_req(16'h8000, 16'h8000, 16'h8000, 1'b1, 16'h0000),
      sample_req(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, 16'h0000),
      // last cell of the store, neighbors outside the dims
      sample_req(16'h1F00, 16'h1F00, 16'h1F00, 1'b1, 16'hABCD),
      sample_req(16'h0080, 16'h0000, 16'h0000, 1'b0, '0),
      sample_req(16'h0080, 16'h0080, 16'h0080, 1'b0, '0),
      sample_req(16'h00FF, 16'h00FF, 16'h00FF, 1'b0, '0),
      sample_req(16'h0001, 16'h00FF, 16'h0040, 1'b0, '0),
      // low corner at -1 counts as zero
      sample_req(16'hFF80, 16'h0000, 16'h0000, 1'b0, '0),
      sample_req(16'hFFC0, 16'hFF01, 16'hFFFF, 1'b0, '0),
      sample_req(16'h1FFF, 16'h1FFF, 16'h1FFF, 1'b0, '0)
    };
  end

  // phase shapes: reset size, extremes, zero, past the store
  int phase_dims [NUM_PHASES][3] = '{
    '{32, 32, 32}, '{1, 1, 1}, '{0, 5, 5}, '{63, 1, 1}, '{7, 3, 2},
    '{1, 32, 1}, '{4, 4, 4}, '{40, 40, 40}, '{32, 1, 32}
  };

  // main stimulus
  initial begin
    grid_req_t r;
    int idx;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) send_item(directed_rows[i]);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_dims(phase_dims[p][0], phase_dims[p][1], phase_dims[p][2]);
      // load the whole grid when small, else a box of up to 5 cells per axis inside it
      if (dim_x * dim_y * dim_z <= 400) begin
        box_x0 = 0; box_y0 = 0; box_z0 = 0;
        box_w = dim_x; box_h = dim_y; box_d = dim_z;
      end else begin
        box_w = (dim_x < 5) ? dim_x : 5;
        box_h = (dim_y < 5) ? dim_y : 5;
        box_d = (dim_z < 5) ? dim_z : 5;
        box_x0 = $urandom_range(0, dim_x - box_w);
        box_y0 = $urandom_range(0, dim_y - box_h);
        box_z0 = $urandom_range(0, dim_z - box_d);
      end
      for (int z = box_z0; z < box_z0 + box_d; z++)
        for (int y = box_y0; y < box_y0 + box_h; y++)
          for (int x = box_x0; x < box_x0 + box_w; x++) begin
            idx = (z * dim_y + y) * dim_x + x;
            if (idx < tgs_pkg::GRID_CELLS) send_item(write_req(idx, 16'($urandom)));
          end
      // long receiver hold while the sender keeps offering
      if (p == 2 || p == 6) hold_reqs++;
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        if ($urandom_range(0, 3) == 0) begin
          if ($urandom_range(0, 1) == 0) begin
            idx = $urandom_range(0, tgs_pkg::GRID_CELLS - 1);
          end else begin
            idx = ((box_z0 + $urandom_range(0, box_d)) * dim_y
                  + box_y0 + $urandom_range(0, box_h)) * dim_x
                  + box_x0 + $urandom_range(0, box_w);
            idx = idx % tgs_pkg::GRID_CELLS;
          end
          r = write_req(idx, 16'($urandom));
        end else begin
          r = random_sample();
        end
        send_item(r);
      end
      // sender pauses until every density has arrived
      drain();
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // receiver stall pattern, with long holds on request
  int hold_seen = 0;
  int hold_left = 0;
  int stall_mode = 0;
  int stall_cyc = 0;

  always @(posedge clk) begin
    stall_cyc <= stall_cyc + 1;
    if (stall_cyc % 64 == 0) stall_mode <= $urandom_range(0, 3);
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 1) == 0);
        2: out_stall <= (stall_cyc % 4 == 0);
        default: out_stall <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // result check and watchdog
  int idle_cycles = 0;
  logic [15:0] want;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (density_q.size() == 0) begin
          $display("%0t: density with none expected, expected none actual %h",
                   $time, out_density);
          errors++;
        end else begin
          want = density_q.pop_front();
          if (out_density !== want) begin
            $display("%0t: density mismatch, expected %h actual %h",
                     $time, want, out_density);
            errors++;
          end
        end
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
